// ===== hw/rtl/cmap_pkg.sv =====
// ----------------------------------------------------------------------------
// cmap_pkg
// Shared types, register indexes and constants of the scalar to colour map.
// ----------------------------------------------------------------------------
package cmap_pkg;

    localparam int NUM_CH   = 3;
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    localparam int STAGES          = 7;
    localparam int DIV_STAGES      = 4;
    localparam int DIV_BITS        = 8;
    localparam int DIV_STEP_BITS   = DIV_BITS / DIV_STAGES;

    localparam int CFG_INDEX_W     = 3;
    localparam int CFG_DATA_W      = 64;
    localparam int NUM_RANGE_REGS  = 4;

    localparam int REG_MODE   = 0;
    localparam int REG_COUNT  = 1;
    localparam int REG_RANGE0 = 2;

    typedef enum logic [1:0] {
        MODE_RAINBOW = 2'd0,
        MODE_GRAY    = 2'd1,
        MODE_CUSTOM  = 2'd2
    } mode_t;

    typedef logic [NUM_CH-1:0][7:0] rgb_t;

    typedef struct packed {
        logic [7:0] end_r;
        logic [7:0] end_g;
        logic [7:0] end_b;
        logic [7:0] start_r;
        logic [7:0] start_g;
        logic [7:0] start_b;
        logic [7:0] hi;
        logic [7:0] lo;
    } range_t;

    typedef struct packed {
        logic                        rainbow;
        logic [NUM_CH-1:0][11:0]     half;
        rgb_t                        base;
        rgb_t                        dmag;
        logic [NUM_CH-1:0]           dneg;
        logic [7:0]                  num;
        logic [7:0]                  den;
    } sel_t;

    typedef struct packed {
        logic                        rainbow;
        rgb_t                        rain;
        rgb_t                        base;
        logic [NUM_CH-1:0]           neg;
        logic [7:0]                  den;
        logic [NUM_CH-1:0][15:0]     work;
    } pipe_t;

    localparam logic signed [15:0] RB_TOP [NUM_CH] = '{16'sd7650, 16'sd10200, 16'sd7650};
    localparam logic signed [15:0] RB_C1  [NUM_CH] = '{16'sd10200, 16'sd5100, 16'sd2550};
    localparam logic signed [15:0] RB_C2  [NUM_CH] = '{16'sd12750, 16'sd10200, 16'sd5100};

    localparam logic [13:0] RB_SCALE  = 14'd44;
    localparam logic [13:0] RB_OFFSET = 14'd2040;
    localparam logic [24:0] RB_ROUND  = 25'd5;
    localparam logic [24:0] RECIP_10  = 25'd6554;

    function automatic rgb_t range_start(input range_t r);
        range_start = {r.start_b, r.start_g, r.start_r};
    endfunction

    function automatic rgb_t range_end(input range_t r);
        range_end = {r.end_b, r.end_g, r.end_r};
    endfunction

endpackage

// ===== hw/rtl/cmap_cfg.sv =====
// ----------------------------------------------------------------------------
// cmap_cfg
// Configuration registers: mode, range count and the custom range slots.
// ----------------------------------------------------------------------------
module cmap_cfg import cmap_pkg::*; #(
    parameter int RANGES = 4
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output logic [1:0]             mode,
    output logic [2:0]             count,
    output range_t                 ranges [RANGES]
);

    logic [1:0] mode_reg;
    logic [2:0] count_reg;
    range_t     range_reg [RANGES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_RAINBOW;
            count_reg <= '0;
            for (int i = 0; i < RANGES; i++) begin
                range_reg[i] <= '0;
            end
        end else if (cfg_we) begin
            if (int'(cfg_index) == REG_MODE) begin
                mode_reg <= cfg_data[1:0];
            end
            if (int'(cfg_index) == REG_COUNT) begin
                count_reg <= cfg_data[2:0];
            end
            for (int i = 0; i < RANGES; i++) begin
                if (i < NUM_RANGE_REGS && int'(cfg_index) == REG_RANGE0 + i) begin
                    range_reg[i] <= range_t'(cfg_data);
                end
            end
        end
    end

    assign mode  = mode_reg;
    assign count = count_reg;

    always_comb begin
        for (int i = 0; i < RANGES; i++) begin
            ranges[i] = range_reg[i];
        end
    end

endmodule

// ===== hw/rtl/cmap_select.sv =====
// ----------------------------------------------------------------------------
// cmap_select
// First stage: rainbow triangle terms and selection of the winning range.
// ----------------------------------------------------------------------------
module cmap_select import cmap_pkg::*; #(
    parameter int RANGES = 4
) (
    input  logic       aclk,
    input  logic       load,
    input  logic [7:0] value,
    input  logic [1:0] mode,
    input  logic [2:0] count,
    input  range_t     ranges [RANGES],
    output sel_t       sel
);

    localparam logic [2:0] RANGES_LIM = 3'(RANGES);

    sel_t              sel_reg;
    sel_t              sel_next;
    logic [2:0]        cnt_lim;
    logic [13:0]       v;
    logic signed [15:0] sv;
    logic signed [15:0] d1 [NUM_CH];
    logic signed [15:0] d2 [NUM_CH];
    logic signed [15:0] t  [NUM_CH];
    rgb_t              ra;
    rgb_t              rb;

    always_comb begin
        cnt_lim = (count > RANGES_LIM) ? RANGES_LIM : count;
        v  = {6'b0, value} * RB_SCALE + RB_OFFSET;
        sv = signed'({2'b0, v});

        sel_next         = '0;
        sel_next.rainbow = (mode == MODE_RAINBOW);
        sel_next.den     = 8'd1;
        if (mode == MODE_GRAY) begin
            sel_next.base = {value, value, value};
        end else begin
            sel_next.base = {8'hFF, 8'hFF, 8'hFF};
        end

        for (int c = 0; c < NUM_CH; c++) begin
            d1[c] = sv - RB_C1[c];
            d2[c] = sv - RB_C2[c];
            if (d1[c] < 0) begin
                d1[c] = -d1[c];
            end
            if (d2[c] < 0) begin
                d2[c] = -d2[c];
            end
            t[c] = RB_TOP[c] - d1[c] - d2[c];
            if (t[c] < 0) begin
                t[c] = '0;
            end
            sel_next.half[c] = t[c][12:1];
        end

        ra = '0;
        rb = '0;
        if (mode != MODE_RAINBOW && mode != MODE_GRAY) begin
            for (int i = 0; i < RANGES; i++) begin
                if (i < int'(cnt_lim) && value >= ranges[i].lo && value <= ranges[i].hi) begin
                    ra = range_start(ranges[i]);
                    rb = range_end(ranges[i]);
                    sel_next.base = ra;
                    sel_next.num  = value - ranges[i].lo;
                    if (ranges[i].hi == ranges[i].lo) begin
                        sel_next.den = 8'd1;
                    end else begin
                        sel_next.den = ranges[i].hi - ranges[i].lo;
                    end
                    for (int c = 0; c < NUM_CH; c++) begin
                        sel_next.dneg[c] = (rb[c] < ra[c]);
                        sel_next.dmag[c] = (rb[c] < ra[c]) ? ra[c] - rb[c] : rb[c] - ra[c];
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            sel_reg <= sel_next;
        end
    end

    assign sel = sel_reg;

endmodule

// ===== hw/rtl/cmap_prod.sv =====
// ----------------------------------------------------------------------------
// cmap_prod
// Second stage: rainbow scaling by one tenth and the interpolation products.
// ----------------------------------------------------------------------------
module cmap_prod import cmap_pkg::*; (
    input  logic  aclk,
    input  logic  load,
    input  sel_t  sel,
    output pipe_t prod
);

    pipe_t                   prod_reg;
    pipe_t                   prod_next;
    logic [NUM_CH-1:0][24:0] rb_prod;

    always_comb begin
        prod_next         = '0;
        prod_next.rainbow = sel.rainbow;
        prod_next.base    = sel.base;
        prod_next.neg     = sel.dneg;
        prod_next.den     = sel.den;
        for (int c = 0; c < NUM_CH; c++) begin
            rb_prod[c]        = ({13'b0, sel.half[c]} + RB_ROUND) * RECIP_10;
            prod_next.rain[c] = rb_prod[c][23:16];
            prod_next.work[c] = {8'b0, sel.dmag[c]} * {8'b0, sel.num};
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

// ===== hw/rtl/cmap_div_step.sv =====
// ----------------------------------------------------------------------------
// cmap_div_step
// One stage of the restoring divider: two quotient bits per channel.
// ----------------------------------------------------------------------------
module cmap_div_step import cmap_pkg::*; (
    input  logic  aclk,
    input  logic  load,
    input  pipe_t p_in,
    output pipe_t p_out
);

    pipe_t       step_reg;
    pipe_t       step_next;
    logic [15:0] w;
    logic [8:0]  trial;

    always_comb begin
        step_next = p_in;
        w         = '0;
        trial     = '0;
        for (int c = 0; c < NUM_CH; c++) begin
            w = p_in.work[c];
            for (int s = 0; s < DIV_STEP_BITS; s++) begin
                trial = {w[15:8], w[7]};
                if (trial >= {1'b0, p_in.den}) begin
                    w = {8'(trial - {1'b0, p_in.den}), w[6:0], 1'b1};
                end else begin
                    w = {trial[7:0], w[6:0], 1'b0};
                end
            end
            step_next.work[c] = w;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            step_reg <= step_next;
        end
    end

    assign p_out = step_reg;

endmodule

// ===== hw/rtl/scalar_to_color_map_core.sv =====
// ----------------------------------------------------------------------------
// scalar_to_color_map_core
// Maps an 8-bit scalar sample to an RGB colour: rainbow, grayscale or ranges.
// Samples pass the select, product, divider step and output registers; one
// transaction per cycle is sustained while m_tready is high, through a pipeline with per-stage valid bits.
// Reset clears the stage valid bits and every configuration register.
// ----------------------------------------------------------------------------
module scalar_to_color_map_core import cmap_pkg::*; #(
    parameter int RANGES = 4
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // value
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [23:0]            m_tdata,   // blue, green, red (red in bits 7:0)
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [1:0]        cfg_mode;
    logic [2:0]        cfg_count;
    range_t            cfg_ranges [RANGES];
    sel_t              sel;
    pipe_t             pipe [DIV_STAGES+1];
    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] vld_next;
    logic [STAGES:0]   rdy;
    rgb_t              rgb_reg;
    rgb_t              rgb_next;

    cmap_cfg #(.RANGES(RANGES)) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .mode      (cfg_mode),
        .count     (cfg_count),
        .ranges    (cfg_ranges)
    );

    cmap_select #(.RANGES(RANGES)) u_select (
        .aclk   (aclk),
        .load   (rdy[0]),
        .value  (s_tdata),
        .mode   (cfg_mode),
        .count  (cfg_count),
        .ranges (cfg_ranges),
        .sel    (sel)
    );

    cmap_prod u_prod (
        .aclk (aclk),
        .load (rdy[1]),
        .sel  (sel),
        .prod (pipe[0])
    );

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
        cmap_div_step u_div_step (
            .aclk  (aclk),
            .load  (rdy[k+2]),
            .p_in  (pipe[k]),
            .p_out (pipe[k+1])
        );
    end

    always_comb begin
        rdy[STAGES] = m_tready;
        for (int k = STAGES - 1; k >= 0; k--) begin
            rdy[k] = ~vld_reg[k] | rdy[k+1];
        end
        for (int k = 0; k < STAGES; k++) begin
            if (rdy[k]) begin
                vld_next[k] = (k == 0) ? s_tvalid : vld_reg[(k == 0) ? 0 : k - 1];
            end else begin
                vld_next[k] = vld_reg[k];
            end
        end
    end

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            if (pipe[DIV_STAGES].rainbow) begin
                rgb_next[c] = pipe[DIV_STAGES].rain[c];
            end else if (pipe[DIV_STAGES].neg[c]) begin
                rgb_next[c] = pipe[DIV_STAGES].base[c] - pipe[DIV_STAGES].work[c][7:0];
            end else begin
                rgb_next[c] = pipe[DIV_STAGES].base[c] + pipe[DIV_STAGES].work[c][7:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[STAGES-1]) begin
            rgb_reg <= rgb_next;
        end
    end

    assign s_tready = rdy[0];
    assign m_tvalid = vld_reg[STAGES-1];
    assign m_tdata  = rgb_reg;

`ifndef ASSERT_OFF
    a_full_when_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> &vld_reg)
        else $error("Input blocked while the pipeline has an empty stage.");

    a_entry_captured: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> vld_reg[0])
        else $error("Accepted transaction missing from the first stage.");

    a_exit_presented: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[STAGES-2] && rdy[STAGES-1] |=> m_tvalid)
        else $error("Result lost on the way into the output register.");
`endif

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the scalar to colour map core. A directed table
// covers the rainbow, grayscale and custom range cases first. Random phases
// then follow, each with fresh register settings and most with random idling
// on both channels; one phase adds a long receiver hold-off. Every result
// transaction is checked against the table colour or a local colour predictor.
// ----------------------------------------------------------------------------
module tb_top;
    import cmap_pkg::*;

    localparam int PHASES        = 14;
    localparam int PHASE_SAMPLES = 100;
    localparam int PRESSURE_PHASE = 6;
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = STAGES + 3;
    localparam int REG_SPARE     = REG_RANGE0 + NUM_RANGE_REGS;
    localparam logic [1:0] MODE_ALIAS = 2'd3;
    localparam string CH_NAMES [NUM_CH] = '{"red", "green", "blue"};

    typedef struct packed {
        logic        is_write;
        logic [2:0]  index;
        logic [63:0] data;
        logic [7:0]  value;
        logic        known;
        rgb_t        color;
    } plan_row_t;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [7:0]             s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [23:0]            m_tdata;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    logic [1:0] cfg_mode = '0;
    logic [2:0] cfg_count = '0;
    range_t     cfg_ranges [NUM_RANGE_REGS] = '{default: '0};

    rgb_t      pending_colors [$];
    plan_row_t directed_plan [$];
    rgb_t      got_color;
    rgb_t      want_color;
    int        errors = 0;
    int        idle_cycles = 0;
    int        idle_pct = 0;
    logic      hold_off = 1'b0;

    scalar_to_color_map_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    function automatic logic [7:0] rainbow_level(input int v, input int top,
                                                 input int c1, input int c2);
        int t;
        t = top - (v > c1 ? v - c1 : c1 - v) - (v > c2 ? v - c2 : c2 - v);
        if (t < 0) t = 0;
        return 8'((t / 2 + 5) / 10);
    endfunction

    function automatic logic [7:0] blend(input int a, input int b, input int num,
                                         input int den);
        return 8'(a + ((b - a) * num) / den);
    endfunction

    function automatic rgb_t map_scalar(input logic [7:0] value);
        int     val;
        int     v;
        int     used;
        int     lo;
        int     hi;
        range_t rg;
        rgb_t   c;
        val = value;
        if (cfg_mode == MODE_RAINBOW) begin
            v = 44 * val + 2040;
            c[CH_RED]   = rainbow_level(v, 7650, 10200, 12750);
            c[CH_GREEN] = rainbow_level(v, 10200, 5100, 10200);
            c[CH_BLUE]  = rainbow_level(v, 7650, 2550, 5100);
        end else if (cfg_mode == MODE_GRAY) begin
            c = {NUM_CH{value}};
        end else begin
            c = {NUM_CH{8'hFF}};
            used = (cfg_count > NUM_RANGE_REGS) ? NUM_RANGE_REGS : cfg_count;
            for (int i = 0; i < used; i++) begin
                rg = cfg_ranges[i];
                lo = rg.lo;
                hi = rg.hi;
                if (val >= lo && val <= hi) begin
                    if (lo == hi) begin
                        c[CH_RED]   = rg.start_r;
                        c[CH_GREEN] = rg.start_g;
                        c[CH_BLUE]  = rg.start_b;
                    end else begin
                        c[CH_RED]   = blend(rg.start_r, rg.end_r, val - lo, hi - lo);
                        c[CH_GREEN] = blend(rg.start_g, rg.end_g, val - lo, hi - lo);
                        c[CH_BLUE]  = blend(rg.start_b, rg.end_b, val - lo, hi - lo);
                    end
                end
            end
        end
        return c;
    endfunction

    function automatic logic [63:0] pack_range(input logic [7:0] lo, input logic [7:0] hi,
                                               input logic [23:0] from_rgb,
                                               input logic [23:0] to_rgb);
        range_t r;
        r.lo      = lo;
        r.hi      = hi;
        r.start_r = from_rgb[23:16];
        r.start_g = from_rgb[15:8];
        r.start_b = from_rgb[7:0];
        r.end_r   = to_rgb[23:16];
        r.end_g   = to_rgb[15:8];
        r.end_b   = to_rgb[7:0];
        return r;
    endfunction

    function automatic logic [63:0] random_range();
        logic [63:0] w;
        logic [7:0]  lo;
        logic [7:0]  hi;
        int          kind;
        w    = {$urandom, $urandom};
        kind = $urandom_range(0, 9);
        lo   = 8'($urandom_range(0, 255));
        if (kind == 0) begin
            hi = lo;
        end else if (kind == 1) begin
            lo = 8'($urandom_range(1, 255));
            hi = 8'($urandom_range(0, lo - 1));
        end else begin
            hi = 8'($urandom_range(lo, 255));
        end
        if (kind == 2) w[63:16] = {24'hFFFFFF, 24'h000000};
        if (kind == 3) w[63:16] = {24'h000000, 24'hFFFFFF};
        w[15:0] = {hi, lo};
        return w;
    endfunction

    function automatic logic [7:0] pick_value();
        int     used;
        range_t rg;
        used = (cfg_count > NUM_RANGE_REGS) ? NUM_RANGE_REGS : cfg_count;
        if (cfg_mode >= MODE_CUSTOM && used > 0 && $urandom_range(0, 9) < 7) begin
            rg = cfg_ranges[$urandom_range(0, used - 1)];
            return 8'($urandom_range(rg.hi, rg.lo));
        end
        if ($urandom_range(0, 19) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic plan_row_t reg_row(input int idx, input logic [63:0] data);
        plan_row_t r;
        r          = '0;
        r.is_write = 1'b1;
        r.index    = 3'(idx);
        r.data     = data;
        return r;
    endfunction

    function automatic plan_row_t sample_row(input logic [7:0] value);
        plan_row_t r;
        r       = '0;
        r.value = value;
        return r;
    endfunction

    function automatic plan_row_t known_row(input logic [7:0] value, input logic [23:0] rgb24);
        plan_row_t r;
        r       = '0;
        r.value = value;
        r.known = 1'b1;
        r.color = {rgb24[7:0], rgb24[15:8], rgb24[23:16]};
        return r;
    endfunction

    function automatic void add_row(input plan_row_t r);
        directed_plan.insert(directed_plan.size(), r);
    endfunction

    task automatic write_reg(input int idx, input logic [63:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_INDEX_W'(idx);
        cfg_data  <= data;
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
        if (idx == REG_MODE) begin
            cfg_mode = data[1:0];
        end else if (idx == REG_COUNT) begin
            cfg_count = data[2:0];
        end else if (idx >= REG_RANGE0 && idx < REG_SPARE) begin
            cfg_ranges[idx - REG_RANGE0] = data;
        end
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending_colors.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic send_sample(input logic [7:0] value, input rgb_t want);
        if ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_colors.insert(pending_colors.size(), want);
        @(negedge aclk);
    endtask

    initial begin
        plan_row_t   row;
        logic [63:0] word;
        logic [7:0]  value;

        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        aresetn   = 1'b0;

        add_row(known_row(8'd0, 24'h0000CC));
        add_row(known_row(8'd255, 24'hCC0000));
        add_row(sample_row(8'd85));
        add_row(sample_row(8'd128));
        add_row(sample_row(8'd170));
        add_row(reg_row(REG_MODE, 64'(MODE_GRAY)));
        add_row(known_row(8'd0, 24'h000000));
        add_row(known_row(8'd255, 24'hFFFFFF));
        add_row(known_row(8'hA5, 24'hA5A5A5));
        add_row(reg_row(REG_MODE, 64'(MODE_CUSTOM)));
        add_row(known_row(8'd77, 24'hFFFFFF));
        add_row(reg_row(REG_RANGE0, pack_range(8'd10, 8'd10, 24'h123456, 24'hABCDEF)));
        add_row(reg_row(REG_COUNT, 64'd1));
        add_row(known_row(8'd10, 24'h123456));
        add_row(known_row(8'd11, 24'hFFFFFF));
        add_row(reg_row(REG_RANGE0 + 1, pack_range(8'd200, 8'd100, 24'h010203,
                                                   24'h040506)));
        add_row(reg_row(REG_COUNT, 64'd2));
        add_row(known_row(8'd150, 24'hFFFFFF));
        add_row(known_row(8'd10, 24'h123456));
        add_row(reg_row(REG_RANGE0 + 2, pack_range(8'd0, 8'd255, 24'hFF0080,
                                                   24'h00FF80)));
        add_row(reg_row(REG_RANGE0 + 3, pack_range(8'd100, 8'd200, 24'h000000,
                                                   24'hFFFFFF)));
        add_row(reg_row(REG_COUNT, 64'd7));
        add_row(known_row(8'd0, 24'hFF0080));
        add_row(known_row(8'd255, 24'h00FF80));
        add_row(sample_row(8'd10));
        add_row(sample_row(8'd101));
        add_row(sample_row(8'd150));
        add_row(reg_row(REG_SPARE, '1));
        add_row(reg_row(REG_SPARE + 1, 64'h0123456789ABCDEF));
        add_row(sample_row(8'd150));
        add_row(reg_row(REG_MODE, 64'(MODE_ALIAS)));
        add_row(known_row(8'd255, 24'h00FF80));
        add_row(sample_row(8'd200));

        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        idle_pct = 20;
        foreach (directed_plan[i]) begin
            row = directed_plan[i];
            if (row.is_write) begin
                settle();
                write_reg(int'(row.index), row.data);
            end else begin
                send_sample(row.value, row.known ? row.color : map_scalar(row.value));
            end
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            settle();
            if (phase == 4 || phase == 5) begin
                for (int i = 0; i < NUM_RANGE_REGS; i++)
                    write_reg(REG_RANGE0 + i, (phase == 4) ? '0 : '1);
                word      = {$urandom, $urandom};
                word[1:0] = (phase == 4) ? MODE_CUSTOM : MODE_ALIAS;
                write_reg(REG_MODE, word);
                word      = {$urandom, $urandom};
                word[2:0] = (phase == 4) ? 3'd7 : 3'd4;
                write_reg(REG_COUNT, word);
            end else begin
                for (int i = 0; i < NUM_RANGE_REGS; i++)
                    if ($urandom_range(0, 9) < 7) write_reg(REG_RANGE0 + i, random_range());
                word      = {$urandom, $urandom};
                word[1:0] = (phase < 4) ? 2'(phase) : 2'($urandom_range(0, 3));
                write_reg(REG_MODE, word);
                word      = {$urandom, $urandom};
                word[2:0] = 3'($urandom_range(0, 7));
                write_reg(REG_COUNT, word);
            end
            if (phase == PHASES - 1 || phase == PRESSURE_PHASE) begin
                idle_pct = 0;
            end else begin
                idle_pct = 15 * $urandom_range(0, 2);
            end
            if (phase == PRESSURE_PHASE) hold_off = 1'b1;
            repeat (PHASE_SAMPLES) begin
                value = pick_value();
                send_sample(value, map_scalar(value));
            end
        end

        s_tvalid <= 1'b0;
        while (pending_colors.size() != 0) @(posedge aclk);
        repeat (2 * STAGES) @(posedge aclk);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        int burst;
        burst    = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_off = 1'b0;
            end else if (burst > 0) begin
                m_tready <= 1'b0;
                burst--;
            end else if ($urandom_range(0, 99) < idle_pct) begin
                m_tready <= 1'b0;
                burst = $urandom_range(0, 7);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (aresetn && m_tvalid && m_tready) begin
            got_color = m_tdata;
            if (pending_colors.size() == 0) begin
                errors++;
                $error("result transaction %h arrived with no colour pending", m_tdata);
            end else begin
                want_color = pending_colors.pop_front();
                for (int c = 0; c < NUM_CH; c++) begin
                    if (got_color[c] !== want_color[c]) begin
                        errors++;
                        $error("%s: expected %0d, got %0d", CH_NAMES[c], want_color[c],
                               got_color[c]);
                    end
                end
            end
        end
    end

    initial begin
        while (idle_cycles < STALL_LIMIT) @(posedge aclk);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
